FILE: rtl/core/pwmdm_pkg.sv
// Shared types and constants of the PWM duty meter with trimmed-mean filter.
package pwmdm_pkg;

  localparam int CHANNELS_DEF = 4;
  localparam int WINDOW_DEF   = 60;

  localparam logic [14:0] FULL_Q8 = 15'd25600;

  localparam logic [14:0] THR_RST  = 15'd1024;
  localparam logic [4:0]  TRIM_RST = 5'd18;
  localparam logic signed [63:0] COEF_RST [6] = '{
    -64'sd1266, 64'sd299215, -64'sd27013234, 64'sd1163713600,
    64'sd1066814930000, 64'sd649344880000
  };

  localparam logic [2:0] REG_THR  = 3'd0;
  localparam logic [2:0] REG_TRIM = 3'd1;

  localparam logic KIND_EDGE = 1'b0;
  localparam logic KIND_READ = 1'b1;

  localparam int DIV_NW = 48;
  localparam int DIV_DW = 33;
  localparam int DIV_QW = 16;

  typedef struct packed {
    logic        kind;
    logic [1:0]  channel;
    logic [31:0] edge_time;
    logic        pin_level;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  out_channel;
    logic [14:0] duty_corrected;
  } out_item_t;

endpackage

FILE: rtl/core/pwm_duty_meter_trimmed_filter_unit.sv
// Top level of the PWM duty meter with trimmed-mean filter and correction.
// An edge item only updates the channel's period slots. A read item runs a raw-duty
// division (skipped for a zero period), a window append or refill, the rank-based trimmed
// sum over the window memory (one read per cycle), an average division and the polynomial
// correction; its result appears on out_valid for one cycle and must be taken then, since
// the receiver cannot stall. After reset the block clears its window memory and keeps busy
// high meanwhile.
module pwm_duty_meter_trimmed_filter_unit #(
  parameter int CHANNELS = pwmdm_pkg::CHANNELS_DEF,
  parameter int WINDOW   = pwmdm_pkg::WINDOW_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  pwmdm_pkg::in_item_t  in_item,
  output logic                 out_valid,
  output pwmdm_pkg::out_item_t out_item,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [5:0]           paddr,
  input  logic [63:0]          pwdata,
  output logic [63:0]          prdata,
  output logic                 pready
);

  localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int IW    = $clog2(WINDOW);
  localparam int JW    = $clog2(WINDOW + 1);
  localparam int DEPTH = CHANNELS * WINDOW;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(WINDOW + 64);
  localparam int SW    = 15 + $clog2(WINDOW + 2);

  typedef enum logic [15:0] {
    ST_IDLE     = 16'h0001,
    ST_CLEAR    = 16'h0002,
    ST_RAW_GO   = 16'h0004,
    ST_RAW_WAIT = 16'h0008,
    ST_LAST_RD  = 16'h0010,
    ST_LAST_CHK = 16'h0020,
    ST_FILL     = 16'h0040,
    ST_PIVOT    = 16'h0080,
    ST_SCAN     = 16'h0100,
    ST_AVG_GO   = 16'h0200,
    ST_AVG_WAIT = 16'h0400,
    ST_MUL_LO   = 16'h0800,
    ST_MUL_HI   = 16'h1000,
    ST_SAT      = 16'h2000,
    ST_ADD      = 16'h4000,
    ST_DONE     = 16'h8000
  } state_t;

  state_t state_r, state_nxt;

  logic [14:0] thr_r;
  logic [4:0]  trim_r;
  logic signed [63:0] coef_r [6];

  logic [31:0] last_edge_r [CHANNELS];
  logic        toggle_r    [CHANNELS];
  logic [31:0] slot_r      [2*CHANNELS];
  logic        low_r       [CHANNELS];
  logic [IW-1:0] head_r    [CHANNELS];

  logic [14:0] win_mem [DEPTH];
  logic [14:0] rdata_r;
  logic [AW-1:0] raddr, waddr;
  logic [14:0] wdata;
  logic        we;

  logic [CH_W-1:0] ch_r;
  logic [1:0]      och_r;
  logic [AW-1:0]   base_r;
  logic [AW-1:0]   clr_r;
  logic [47:0]     num_r;
  logic [32:0]     s_r;
  logic [14:0]     raw_r;
  logic [14:0]     pivot_r;
  logic [JW-1:0]   i_r, j_r, rank_r;
  logic [SW-1:0]   sum_r;
  logic [15:0]     avg_r;
  logic signed [63:0] acc_r, m_r;
  logic signed [79:0] prod_r;
  logic [2:0]      k_r;
  logic            out_valid_r;
  pwmdm_pkg::out_item_t out_item_r;

  logic            accept, ch_ok;
  logic [CH_W-1:0] ch_in;
  logic [31:0]     lo_t, hi_t;
  logic [32:0]     s_in;
  logic            div_go, div_done;
  logic [47:0]     div_num;
  logic [32:0]     div_den;
  logic [15:0]     div_q;
  logic [14:0]     diff;
  logic            jump;
  logic [JW-1:0]   jm1, rank_new;
  logic            lt;
  logic [CW-1:0]   two_t, n_cnt, lo_rank, hi_rank, rank_ext;
  logic [IW-1:0]   head_cur, last_idx;
  logic signed [32:0] mop;
  logic signed [48:0] mres;
  logic signed [71:0] qsh;
  logic signed [64:0] ssum;
  logic signed [63:0] coef_k;
  logic [2:0]      cfg_idx;
  logic            cfg_we;

  assign accept   = start && !busy;
  assign ch_ok    = 32'(in_item.channel) < CHANNELS;
  assign ch_in    = CH_W'(in_item.channel);
  assign lo_t     = slot_r[{ch_in, low_r[ch_in]}];
  assign hi_t     = slot_r[{ch_in, ~low_r[ch_in]}];
  assign s_in     = {1'b0, lo_t} + {1'b0, hi_t};
  assign head_cur = head_r[ch_r];
  assign last_idx = (head_cur == '0) ? IW'(WINDOW - 1) : IW'(head_cur - 1'b1);
  assign diff     = (rdata_r > raw_r) ? 15'(rdata_r - raw_r) : 15'(raw_r - rdata_r);
  assign jump     = diff >= thr_r;
  assign jm1      = j_r - 1'b1;
  assign lt       = (rdata_r < pivot_r) || ((rdata_r == pivot_r) && (jm1 < i_r));
  assign rank_new = rank_r + JW'(lt);
  assign two_t    = CW'({trim_r, 1'b0});
  assign n_cnt    = (two_t < CW'(WINDOW)) ? CW'(CW'(WINDOW) - two_t) : '0;
  assign lo_rank  = CW'(trim_r);
  assign hi_rank  = lo_rank + n_cnt;
  assign rank_ext = CW'(rank_new);
  assign coef_k   = coef_r[k_r];
  assign mop      = state_r == ST_MUL_LO ? $signed({1'b0, acc_r[31:0]})
                                         : $signed({acc_r[63], acc_r[63:32]});
  assign mres     = mop * $signed({1'b0, avg_r});
  assign qsh      = 72'(prod_r >>> 8);
  assign ssum     = $signed({m_r[63], m_r}) + $signed({coef_k[63], coef_k});
  assign cfg_idx  = paddr[5:3];
  assign cfg_we   = psel && penable && pwrite;

  assign div_go  = (state_r == ST_RAW_GO) || (state_r == ST_AVG_GO);
  assign div_num = (state_r == ST_RAW_GO) ? num_r : 48'(sum_r);
  assign div_den = (state_r == ST_RAW_GO) ? s_r : 33'(n_cnt) + 33'd1;

  pwmdm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (div_go),
    .numer (div_num),
    .denom (div_den),
    .done  (div_done),
    .quot  (div_q)
  );

  always_comb begin
    raddr = base_r + AW'(j_r[IW-1:0]);
    we    = 1'b0;
    waddr = base_r + AW'(head_cur);
    wdata = raw_r;
    unique case (state_r)
      ST_LAST_RD: raddr = base_r + AW'(last_idx);
      ST_PIVOT:   raddr = base_r + AW'(i_r[IW-1:0]);
      ST_CLEAR: begin
        we    = 1'b1;
        waddr = clr_r;
        wdata = '0;
      end
      ST_FILL: begin
        we    = 1'b1;
        waddr = base_r + AW'(j_r[IW-1:0]);
      end
      ST_LAST_CHK: we = !jump;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      win_mem[waddr] <= wdata;
    end
    rdata_r <= win_mem[raddr];
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && ch_ok && in_item.kind == pwmdm_pkg::KIND_READ) begin
          state_nxt = ST_RAW_GO;
        end
      end
      ST_CLEAR:    if (clr_r == AW'(DEPTH - 1)) state_nxt = ST_IDLE;
      ST_RAW_GO:   state_nxt = (s_r == '0) ? ST_LAST_RD : ST_RAW_WAIT;
      ST_RAW_WAIT: if (div_done) state_nxt = ST_LAST_RD;
      ST_LAST_RD:  state_nxt = ST_LAST_CHK;
      ST_LAST_CHK: state_nxt = jump ? ST_FILL : ST_PIVOT;
      ST_FILL:     if (j_r == JW'(WINDOW - 1)) state_nxt = ST_PIVOT;
      ST_PIVOT:    state_nxt = ST_SCAN;
      ST_SCAN: begin
        if (j_r == JW'(WINDOW)) begin
          state_nxt = (i_r == JW'(WINDOW - 1)) ? ST_AVG_GO : ST_PIVOT;
        end
      end
      ST_AVG_GO:   state_nxt = ST_AVG_WAIT;
      ST_AVG_WAIT: if (div_done) state_nxt = ST_MUL_LO;
      ST_MUL_LO:   state_nxt = ST_MUL_HI;
      ST_MUL_HI:   state_nxt = ST_SAT;
      ST_SAT:      state_nxt = ST_ADD;
      ST_ADD:      state_nxt = (k_r == 3'd5) ? ST_DONE : ST_MUL_LO;
      ST_DONE:     state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      thr_r       <= pwmdm_pkg::THR_RST;
      trim_r      <= pwmdm_pkg::TRIM_RST;
      for (int c = 0; c < 6; c++) begin
        coef_r[c] <= pwmdm_pkg::COEF_RST[c];
      end
      for (int c = 0; c < CHANNELS; c++) begin
        last_edge_r[c]   <= '0;
        toggle_r[c]      <= 1'b0;
        low_r[c]         <= 1'b0;
        head_r[c]        <= '0;
        slot_r[2*c]      <= '0;
        slot_r[2*c + 1]  <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == ST_DONE);
      if (cfg_we) begin
        unique case (cfg_idx)
          pwmdm_pkg::REG_THR:  thr_r  <= pwdata[14:0];
          pwmdm_pkg::REG_TRIM: trim_r <= pwdata[4:0];
          default:             coef_r[cfg_idx - 3'd2] <= pwdata;
        endcase
      end
      unique case (state_r)
        ST_CLEAR: clr_r <= clr_r + 1'b1;
        ST_IDLE: begin
          if (accept && ch_ok) begin
            if (in_item.kind == pwmdm_pkg::KIND_EDGE) begin
              slot_r[{ch_in, toggle_r[ch_in]}] <= in_item.edge_time - last_edge_r[ch_in];
              if (in_item.pin_level) begin
                low_r[ch_in] <= toggle_r[ch_in];
              end
              toggle_r[ch_in]    <= ~toggle_r[ch_in];
              last_edge_r[ch_in] <= in_item.edge_time;
            end else begin
              ch_r   <= ch_in;
              och_r  <= in_item.channel;
              base_r <= AW'(ch_in) * AW'(WINDOW);
              num_r  <= 48'(pwmdm_pkg::FULL_Q8) * 48'(hi_t);
              s_r    <= s_in;
            end
          end
        end
        ST_RAW_GO:   raw_r <= pwmdm_pkg::FULL_Q8;
        ST_RAW_WAIT: if (div_done) raw_r <= div_q[14:0];
        ST_LAST_CHK: begin
          sum_r <= SW'(raw_r);
          i_r   <= '0;
          j_r   <= '0;
          if (!jump) begin
            head_r[ch_r] <= (head_cur == IW'(WINDOW - 1)) ? '0 : IW'(head_cur + 1'b1);
          end
        end
        ST_FILL: j_r <= (j_r == JW'(WINDOW - 1)) ? '0 : JW'(j_r + 1'b1);
        ST_PIVOT: j_r <= '0;
        ST_SCAN: begin
          if (j_r == '0) begin
            pivot_r <= rdata_r;
            rank_r  <= '0;
          end else begin
            rank_r <= rank_new;
          end
          j_r <= j_r + 1'b1;
          if (j_r == JW'(WINDOW)) begin
            if (rank_ext >= lo_rank && rank_ext < hi_rank) begin
              sum_r <= sum_r + SW'(pivot_r);
            end
            i_r <= i_r + 1'b1;
          end
        end
        ST_AVG_WAIT: begin
          if (div_done) begin
            avg_r <= div_q;
            acc_r <= coef_r[0];
            k_r   <= 3'd1;
          end
        end
        ST_MUL_LO: prod_r <= 80'(mres);
        ST_MUL_HI: prod_r <= prod_r + (80'(mres) <<< 32);
        ST_SAT: begin
          if (qsh > 72'sh7fffffffffffffff) begin
            m_r <= 64'sh7fffffffffffffff;
          end else if (qsh < -72'sh8000000000000000) begin
            m_r <= 64'sh8000000000000000;
          end else begin
            m_r <= 64'(qsh);
          end
        end
        ST_ADD: begin
          if (ssum[64] != ssum[63]) begin
            acc_r <= ssum[64] ? 64'sh8000000000000000 : 64'sh7fffffffffffffff;
          end else begin
            acc_r <= ssum[63:0];
          end
          k_r <= k_r + 3'd1;
        end
        ST_DONE: begin
          out_item_r.out_channel <= och_r;
          if (acc_r[63]) begin
            out_item_r.duty_corrected <= '0;
          end else if (acc_r[62:32] > 31'(pwmdm_pkg::FULL_Q8)) begin
            out_item_r.duty_corrected <= pwmdm_pkg::FULL_Q8;
          end else begin
            out_item_r.duty_corrected <= acc_r[46:32];
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      pwmdm_pkg::REG_THR:  prdata = 64'(thr_r);
      pwmdm_pkg::REG_TRIM: prdata = 64'(trim_r);
      default:             prdata = coef_r[cfg_idx - 3'd2];
    endcase
  end

  assign pready    = 1'b1;
  assign busy      = state_r != ST_IDLE;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held longer than one cycle");

  a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_item.duty_corrected <= pwmdm_pkg::FULL_Q8)
    else $error("duty result out of range");

  a_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && ch_ok && in_item.kind == pwmdm_pkg::KIND_READ) |=> busy && !out_valid)
    else $error("read item did not start the sequencer");

  a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> !out_valid)
    else $error("result during memory clear");

endmodule

FILE: rtl/core/pwmdm_div.sv
// Iterative restoring divider, one quotient bit per cycle.
module pwmdm_div #(
  parameter int NW = pwmdm_pkg::DIV_NW,
  parameter int DW = pwmdm_pkg::DIV_DW,
  parameter int QW = pwmdm_pkg::DIV_QW
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          go,
  input  logic [NW-1:0] numer,
  input  logic [DW-1:0] denom,
  output logic          done,
  output logic [QW-1:0] quot
);

  localparam int CNTW = $clog2(NW + 1);

  logic [DW-1:0]   rem_r;
  logic [DW-1:0]   den_r;
  logic [NW-1:0]   num_r;
  logic [QW-1:0]   q_r;
  logic [CNTW-1:0] cnt_r;
  logic            run_r;
  logic            done_r;
  logic [DW:0]     shifted;
  logic            ge;

  assign shifted = {rem_r, num_r[NW-1]};
  assign ge      = shifted >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= !go && run_r && (cnt_r == CNTW'(1));
      if (go) begin
        run_r <= 1'b1;
        cnt_r <= CNTW'(NW);
        rem_r <= '0;
        q_r   <= '0;
        num_r <= numer;
        den_r <= denom;
      end else if (run_r) begin
        rem_r <= ge ? DW'(shifted - {1'b0, den_r}) : DW'(shifted);
        q_r   <= {q_r[QW-2:0], ge};
        num_r <= {num_r[NW-2:0], 1'b0};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNTW'(1)) begin
          run_r <= 1'b0;
        end
      end
    end
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

FILE: tb/sv/pwm_duty_meter_trimmed_filter_unit_tb.sv
// Self-checking testbench for the PWM duty meter with trimmed-mean filter and correction.
module pwm_duty_meter_trimmed_filter_unit_tb;

  localparam int NCH = 4;
  localparam int WIN = 60;
  localparam int WATCHDOG_LIMIT = 40000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  pwmdm_pkg::in_item_t in_item = '0;
  logic out_valid;
  pwmdm_pkg::out_item_t out_item;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [5:0] paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic pready;

  pwm_duty_meter_trimmed_filter_unit dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Predictor state and configuration copy.
  logic [14:0] thr_q8;
  logic [4:0] trim;
  logic signed [63:0] coef [6];
  logic [31:0] last_edge [NCH];
  logic toggle [NCH];
  logic [31:0] slots [NCH][2];
  logic low_idx [NCH];
  logic [14:0] window [NCH][WIN];

  pwmdm_pkg::in_item_t pending_items [$];
  pwmdm_pkg::out_item_t expected_duty [$];
  int mismatches = 0;
  int idle_cycles = 0;
  logic took = 1'b0;
  int burst_left = 4;
  int gap_left = 0;
  logic [31:0] stamp [NCH];

  function automatic logic signed [63:0] sat_add(logic signed [63:0] a, logic signed [63:0] b);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    if (s > 65'sh0_7fff_ffff_ffff_ffff) return 64'sh7fff_ffff_ffff_ffff;
    if (s < -65'sh0_8000_0000_0000_0000) return 64'sh8000_0000_0000_0000;
    return s[63:0];
  endfunction

  function automatic logic signed [63:0] scale_q8(logic signed [63:0] a, logic [15:0] x);
    logic signed [127:0] p;
    p = 128'(a) * $signed({112'd0, x});
    p = p >>> 8;
    if (p > 128'sh7fff_ffff_ffff_ffff) return 64'sh7fff_ffff_ffff_ffff;
    if (p < -128'sh8000_0000_0000_0000) return 64'sh8000_0000_0000_0000;
    return p[63:0];
  endfunction

  function automatic void predict_duty(pwmdm_pkg::in_item_t it);
    int ch;
    logic tg;
    logic [32:0] total;
    logic [47:0] num;
    logic [15:0] raw, lastv, diff, avg;
    int srt [WIN];
    int v, j, n;
    logic [31:0] acc_sum;
    logic signed [63:0] acc;
    logic [31:0] q;
    pwmdm_pkg::out_item_t res;
    ch = it.channel;
    if (it.kind == pwmdm_pkg::KIND_EDGE) begin
      tg = toggle[ch];
      slots[ch][tg] = it.edge_time - last_edge[ch];
      if (it.pin_level) low_idx[ch] = tg;
      toggle[ch] = ~tg;
      last_edge[ch] = it.edge_time;
      return;
    end
    total = {1'b0, slots[ch][0]} + {1'b0, slots[ch][1]};
    if (total == 0) begin
      raw = 16'(pwmdm_pkg::FULL_Q8);
    end else begin
      num = 48'(pwmdm_pkg::FULL_Q8) * 48'(total - {1'b0, slots[ch][low_idx[ch]]});
      raw = 16'(num / 48'(total));
    end
    lastv = 16'(window[ch][WIN-1]);
    for (int i = 0; i < WIN - 1; i++) window[ch][i] = window[ch][i+1];
    diff = lastv > raw ? lastv - raw : raw - lastv;
    if (diff < 16'(thr_q8)) begin
      window[ch][WIN-1] = raw[14:0];
    end else begin
      for (int i = 0; i < WIN; i++) window[ch][i] = raw[14:0];
    end
    for (int i = 0; i < WIN; i++) srt[i] = window[ch][i];
    for (int i = 1; i < WIN; i++) begin
      v = srt[i];
      j = i;
      while (j > 0 && srt[j-1] > v) begin
        srt[j] = srt[j-1];
        j--;
      end
      srt[j] = v;
    end
    n = (2 * trim < WIN) ? WIN - 2 * trim : 0;
    acc_sum = raw;
    for (int i = 0; i < n; i++) acc_sum += srt[trim + i];
    avg = 16'(acc_sum / (n + 1));
    acc = coef[0];
    for (int i = 1; i < 6; i++) acc = sat_add(scale_q8(acc, avg), coef[i]);
    res.out_channel = it.channel;
    if (acc < 0) begin
      res.duty_corrected = '0;
    end else begin
      q = acc[63:32];
      res.duty_corrected = q > 32'(pwmdm_pkg::FULL_Q8) ? pwmdm_pkg::FULL_Q8 : q[14:0];
    end
    expected_duty.push_back(res);
  endfunction

  // Input acceptance and result checking.
  always @(posedge clk) begin
    if (rst_n) begin
      took <= start && !busy;
      if (start && !busy) begin
        predict_duty(pending_items.pop_front());
      end
      if ((start && !busy) || out_valid) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (out_valid) begin
        if (expected_duty.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("Unexpected result: ch %0d duty %0d",
                                         out_item.out_channel, out_item.duty_corrected);
        end else begin
          pwmdm_pkg::out_item_t e;
          e = expected_duty.pop_front();
          if (e.out_channel !== out_item.out_channel ||
              e.duty_corrected !== out_item.duty_corrected) begin
            mismatches++;
            if (mismatches <= 10)
              $display("Mismatch: expected ch %0d duty %0d, got ch %0d duty %0d",
                       e.out_channel, e.duty_corrected,
                       out_item.out_channel, out_item.duty_corrected);
          end
        end
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end else begin
      took <= 1'b0;
    end
  end

  // Item driver with random bursts and gaps.
  always @(negedge clk) begin
    if (took) begin
      burst_left = burst_left - 1;
      if (burst_left <= 0) begin
        burst_left = $urandom_range(1, 8);
        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      end
    end
    if (gap_left > 0) begin
      gap_left = gap_left - 1;
      start <= 1'b0;
    end else if (pending_items.size() > 0) begin
      start <= 1'b1;
      in_item <= pending_items[0];
    end else begin
      start <= 1'b0;
    end
  end

  task automatic cfg_write(input logic [2:0] idx, input logic [63:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == pwmdm_pkg::REG_THR) thr_q8 = value[14:0];
    else if (idx == pwmdm_pkg::REG_TRIM) trim = value[4:0];
    else coef[idx - 3'd2] = value;
  endtask

  task automatic wait_idle();
    wait (pending_items.size() == 0 && expected_duty.size() == 0);
    @(negedge clk);
    while (busy || start) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  function automatic void add_item(logic kind, logic [1:0] ch, logic [31:0] t, logic pin);
    pwmdm_pkg::in_item_t it;
    it.kind = kind;
    it.channel = ch;
    it.edge_time = t;
    it.pin_level = pin;
    pending_items.push_back(it);
  endfunction

  task automatic add_random(input int count);
    int made;
    logic [1:0] ch;
    logic pin;
    made = 0;
    while (made < count) begin
      if ($urandom_range(0, 9) < 8) begin
        ch = 2'($urandom_range(0, 3));
        pin = 1'($urandom_range(0, 1));
        for (int k = $urandom_range(2, 4); k > 0; k--) begin
          stamp[ch] += ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(1, 3000);
          add_item(pwmdm_pkg::KIND_EDGE, ch, stamp[ch], pin);
          pin = ~pin;
          made++;
        end
        add_item(pwmdm_pkg::KIND_READ, ch, $urandom, 1'($urandom_range(0, 1)));
      end else begin
        add_item(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)), $urandom,
                 1'($urandom_range(0, 1)));
      end
      made++;
    end
  endtask

  initial begin
    thr_q8 = pwmdm_pkg::THR_RST;
    trim = pwmdm_pkg::TRIM_RST;
    for (int i = 0; i < 6; i++) coef[i] = pwmdm_pkg::COEF_RST[i];
    for (int c = 0; c < NCH; c++) begin
      last_edge[c] = '0;
      toggle[c] = 1'b0;
      slots[c][0] = '0;
      slots[c][1] = '0;
      low_idx[c] = 1'b0;
      stamp[c] = $urandom;
      for (int i = 0; i < WIN; i++) window[c][i] = '0;
    end
    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    while (busy) @(negedge clk);

    // Directed items at reset settings: no time seen, extremes, wrap-around, all channels.
    add_item(pwmdm_pkg::KIND_READ, 2'd0, 32'hffff_ffff, 1'b1);
    add_item(pwmdm_pkg::KIND_EDGE, 2'd0, 32'h0000_0000, 1'b1);
    add_item(pwmdm_pkg::KIND_EDGE, 2'd0, 32'hffff_ffff, 1'b0);
    add_item(pwmdm_pkg::KIND_READ, 2'd0, 32'h0, 1'b0);
    add_item(pwmdm_pkg::KIND_EDGE, 2'd1, 32'hffff_fff0, 1'b0);
    add_item(pwmdm_pkg::KIND_EDGE, 2'd1, 32'h0000_0010, 1'b1);
    add_item(pwmdm_pkg::KIND_EDGE, 2'd1, 32'h0000_0110, 1'b0);
    add_item(pwmdm_pkg::KIND_READ, 2'd1, 32'h0, 1'b0);
    add_item(pwmdm_pkg::KIND_EDGE, 2'd2, 32'h0000_0100, 1'b1);
    add_item(pwmdm_pkg::KIND_EDGE, 2'd2, 32'h0000_0100, 1'b0);
    add_item(pwmdm_pkg::KIND_READ, 2'd2, 32'h5555_5555, 1'b1);
    add_item(pwmdm_pkg::KIND_EDGE, 2'd3, 32'h8000_0000, 1'b0);
    add_item(pwmdm_pkg::KIND_EDGE, 2'd3, 32'h8000_0001, 1'b0);
    add_item(pwmdm_pkg::KIND_READ, 2'd3, 32'haaaa_aaaa, 1'b0);
    add_item(pwmdm_pkg::KIND_READ, 2'd3, 32'h0, 1'b1);
    add_item(pwmdm_pkg::KIND_EDGE, 2'd3, 32'h8000_1000, 1'b1);
    add_item(pwmdm_pkg::KIND_READ, 2'd3, 32'h0, 1'b0);
    add_random(20);
    wait_idle();

    // Identity correction, no threshold, no trimming.
    cfg_write(pwmdm_pkg::REG_THR, 64'd0);
    cfg_write(pwmdm_pkg::REG_TRIM, 64'd0);
    for (int i = 2; i < 8; i++) cfg_write(3'(i), (i == 6) ? 64'h100_0000_0000 : 64'd0);
    add_random(25);
    wait_idle();

    // Full-scale threshold, trim one below half the window, saturating coefficients.
    cfg_write(pwmdm_pkg::REG_THR, 64'd25600);
    cfg_write(pwmdm_pkg::REG_TRIM, 64'd29);
    cfg_write(3'd2, 64'h7fff_ffff_ffff_ffff);
    cfg_write(3'd3, 64'h8000_0000_0000_0000);
    cfg_write(3'd4, 64'h7fff_ffff_ffff_ffff);
    cfg_write(3'd5, 64'h8000_0000_0000_0000);
    cfg_write(3'd6, 64'h7fff_ffff_ffff_ffff);
    cfg_write(3'd7, 64'h8000_0000_0000_0000);
    add_random(30);
    wait_idle();

    // Random settings with random full-width coefficients.
    cfg_write(pwmdm_pkg::REG_THR, 64'($urandom_range(0, 25600)));
    cfg_write(pwmdm_pkg::REG_TRIM, 64'($urandom_range(0, 29)));
    for (int i = 2; i < 8; i++) cfg_write(3'(i), {$urandom, $urandom});
    add_random(20);
    wait_idle();

    // Back to the default correction with moderate trimming.
    cfg_write(pwmdm_pkg::REG_THR, 64'd512);
    cfg_write(pwmdm_pkg::REG_TRIM, 64'd10);
    for (int i = 2; i < 8; i++) cfg_write(3'(i), pwmdm_pkg::COEF_RST[i - 2]);
    add_random(30);
    wait_idle();

    if (mismatches == 0 && expected_duty.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
